>>> design/shs_pkg.sv
// shared types, constants and round functions of the sha-256 stream hasher
// used by shs_compress and sha256_stream_hasher_core; no dependencies
package shs_pkg;

    localparam logic       OP_ABSORB = 1'b0;
    localparam logic       OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [2:0] LAST_IDX  = 3'd7;

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // commands from the sequencer to the compression unit
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       start;
        logic       chain_init;
        logic       chain_rotate;
    } shs_ctl_t;

    typedef struct packed {
        logic done;
    } shs_sts_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
        ch_fn = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        maj_fn = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

>>> design/shs_compress.sv
// block window, message schedule, one-round-per-cycle compression and chain value
// depends on shs_pkg
module shs_compress
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  shs_ctl_t    ctl,
    output shs_sts_t    sts,
    output logic [31:0] head_word
);

    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  wv_reg [8];
    logic [31:0]  wv_next [8];
    logic [31:0]  chain_reg [8];
    logic         busy_reg;
    logic         fold_reg;
    logic [5:0]   rnd_reg;
    logic [31:0]  w0;
    logic [31:0]  w1;
    logic [31:0]  w9;
    logic [31:0]  w14;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    // oldest schedule word sits in the top 32 bits of the window
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];

    assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

    assign t1 = wv_reg[7] + bsig1(wv_reg[4]) + ch_fn(wv_reg[4], wv_reg[5], wv_reg[6])
              + K_TABLE[rnd_reg] + w0;
    assign t2 = bsig0(wv_reg[0]) + maj_fn(wv_reg[0], wv_reg[1], wv_reg[2]);

    always_comb
    begin
        blk_next = blk_reg;
        if (ctl.shift_byte)
        begin
            blk_next = {blk_reg[503:0], ctl.byte_val};
        end
        else if (busy_reg)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            wv_next[i] = wv_reg[i];
        end
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wv_next[i] = chain_reg[i];
            end
        end
        else if (busy_reg)
        begin
            wv_next[0] = t1 + t2;
            wv_next[1] = wv_reg[0];
            wv_next[2] = wv_reg[1];
            wv_next[3] = wv_reg[2];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[5] = wv_reg[4];
            wv_next[6] = wv_reg[5];
            wv_next[7] = wv_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        for (int i = 0; i < 8; i++)
        begin
            wv_reg[i] <= wv_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fold_reg <= 1'b0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV_TABLE[i];
            end
        end
        else
        begin
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == LAST_POS)
                begin
                    busy_reg <= 1'b0;
                    fold_reg <= 1'b1;
                end
            end

            if (fold_reg)
            begin
                fold_reg <= 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + wv_reg[i];
                end
            end
            else if (ctl.chain_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= IV_TABLE[i];
                end
            end
            else if (ctl.chain_rotate)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    chain_reg[i] <= chain_reg[i + 1];
                end
                chain_reg[7] <= chain_reg[0];
            end
        end
    end

    assign sts.done  = fold_reg;
    assign head_word = chain_reg[0];

endmodule

>>> design/sha256_stream_hasher_core.sv
// top level of the byte-serial sha-256 hasher: byte sequencer, padding and digest output
// depends on shs_pkg and shs_compress
//
// The absorb beat that completes a 64-byte block starts the compression unit, which
// runs one round per cycle for 64 rounds and then folds the working variables into the
// chain value. A finish beat writes padding (0x80, zeros, eight length bytes) up to the
// end of the block, with a second compression when the 0x80 byte leaves fewer than
// eight bytes in the block, and then presents h0..h7 as eight output beats, one per
// cycle unless stalled. The input is stalled while a compression runs, and from a
// finish beat until the eighth digest beat has been taken.
module sha256_stream_hasher_core
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [2:0]  ret_reg;
    logic [2:0]  ret_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [63:0] count_reg;
    logic [63:0] count_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    shs_ctl_t    ctl;
    shs_sts_t    sts;
    logic [31:0] head_word;

    shs_compress u_compress (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .head_word (head_word)
    );

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.shift_byte = 1'b1;
                    fill_next      = fill_reg + 6'd1;
                    if (op == OP_ABSORB)
                    begin
                        ctl.byte_val = data_byte;
                        count_next   = count_reg + 64'd1;
                        ret_next     = ST_IDLE;
                    end
                    else
                    begin
                        ctl.byte_val = PAD_BYTE;
                        len_next     = {count_reg[60:0], 3'b000};
                        ret_next     = ST_PAD;
                        state_next   = ST_PAD;
                    end
                    if (fill_reg == LAST_POS)
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LEN_POS)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    ctl.shift_byte = 1'b1;
                    ctl.byte_val   = 8'h00;
                    fill_next      = fill_reg + 6'd1;
                    if (fill_reg == LAST_POS)
                    begin
                        // padding spilled into an extra block
                        ctl.start  = 1'b1;
                        ret_next   = ST_PAD;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_LEN:
            begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = len_reg[63:56];
                len_next       = {len_reg[55:0], 8'h00};
                fill_next      = fill_reg + 6'd1;
                if (fill_reg == LAST_POS)
                begin
                    ctl.start  = 1'b1;
                    ret_next   = ST_OUT;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sts.done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next         = idx_reg + 3'd1;
                    ctl.chain_rotate = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        ctl.chain_init = 1'b1;
                        count_next     = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = head_word;
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_IDX);

endmodule

>>> design/shs_checker.sv
// port-level checks on the sha-256 hasher's sequencing and digest beats
// bound to sha256_stream_hasher_core; depends on nothing else
module shs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // last beat flag matches the final word position
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // digest beats come in order without gaps
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=>
            out_valid && (word_index == $past(word_index) + 3'd1))
        else $error("digest beat out of order");

    // no new input while digest beats are pending
    a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during digest output");

    // output ends after the last beat
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> !out_valid)
        else $error("digest output continues past last word");

    // a finish beat never shows a digest in the next cycle
    a_finish_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op |=> !out_valid)
        else $error("digest appeared right after finish");

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .last_word  (last_word)
);
